FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check sampled on the rising clock edge, masked while reset is high.
`define SDF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check sampled on every rising clock edge, reset cycles included.
`define SDF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/sdf_pkg.sv
`default_nettype none

package sdf_pkg;

   localparam int VALUE_W       = 32;
   localparam int NUM_DIGITS    = 10;
   localparam int DIGIT_W       = 4;
   localparam int BCD_W         = NUM_DIGITS * DIGIT_W;
   localparam int NDIG_W        = 4;
   localparam int CHAR_W        = 8;
   localparam int PREC_W        = 6;
   localparam int WIDTH_W       = 7;
   localparam int MAX_OUT_CHARS = 64;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

   // top -> converter
   typedef struct packed {
      logic start;   // load a new magnitude
      logic shift;   // drop the leading digit
   } conv_ctrl_type;

   // converter -> top
   typedef struct packed {
      logic              done;  // digits ready, ndig valid
      logic [NDIG_W-1:0] ndig;  // significant digit count, 1..10
   } conv_stat_type;

endpackage

`default_nettype wire

FILE: rtl/sdf_bin2bcd.sv
`default_nettype none
`include "assert_macros.svh"

module sdf_bin2bcd (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire sdf_pkg::conv_ctrl_type         ctrl,
   input  wire logic [sdf_pkg::VALUE_W-1:0]    mag,
   output sdf_pkg::conv_stat_type              stat,
   output logic [sdf_pkg::DIGIT_W-1:0]         top_digit
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_DABBLE = 2'd1;
   localparam logic [1:0] ST_NORM   = 2'd2;
   localparam logic [1:0] ST_READY  = 2'd3;

   localparam int CNT_W = $clog2(sdf_pkg::VALUE_W);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(sdf_pkg::VALUE_W - 1);

   logic [1:0]                   state_ff, state_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic [sdf_pkg::VALUE_W-1:0]  bin_ff, bin_in;
   logic [sdf_pkg::BCD_W-1:0]    bcd_ff, bcd_in;
   logic [sdf_pkg::NDIG_W-1:0]   ndig_ff, ndig_in;
   logic [sdf_pkg::BCD_W-1:0]    bcd_adj;

   // add 3 to every digit of 5 or more before the shift
   function automatic logic [sdf_pkg::BCD_W-1:0] dabble_adj(
      input logic [sdf_pkg::BCD_W-1:0] b);
      logic [sdf_pkg::BCD_W-1:0] r;
      logic [sdf_pkg::DIGIT_W-1:0] d;
      r = b;
      for (int i = 0; i < sdf_pkg::NUM_DIGITS; i++) begin
         d = b[i*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W];
         if (d >= 4'd5) begin
            r[i*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W] = d + 4'd3;
         end
      end
      return r;
   endfunction

   assign bcd_adj   = dabble_adj(bcd_ff);
   assign top_digit = bcd_ff[sdf_pkg::BCD_W-1 -: sdf_pkg::DIGIT_W];
   assign stat.done = (state_ff == ST_READY);
   assign stat.ndig = ndig_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      ndig_in  = ndig_ff;
      if (ctrl.start) begin
         state_in = ST_DABBLE;
         cnt_in   = '0;
         bin_in   = mag;
         bcd_in   = '0;
      end else begin
         case (state_ff)
            ST_DABBLE: begin
               bcd_in = {bcd_adj[sdf_pkg::BCD_W-2:0], bin_ff[sdf_pkg::VALUE_W-1]};
               bin_in = {bin_ff[sdf_pkg::VALUE_W-2:0], 1'b0};
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  state_in = ST_NORM;
                  ndig_in  = sdf_pkg::NDIG_W'(sdf_pkg::NUM_DIGITS);
               end
            end
            ST_NORM: begin
               // strip leading zero digits, keep at least one
               if (ndig_ff > 4'd1 && top_digit == '0) begin
                  bcd_in  = {bcd_ff[sdf_pkg::BCD_W-sdf_pkg::DIGIT_W-1:0],
                             {sdf_pkg::DIGIT_W{1'b0}}};
                  ndig_in = ndig_ff - 1'b1;
               end else begin
                  state_in = ST_READY;
               end
            end
            ST_READY: begin
               if (ctrl.shift) begin
                  bcd_in = {bcd_ff[sdf_pkg::BCD_W-sdf_pkg::DIGIT_W-1:0],
                            {sdf_pkg::DIGIT_W{1'b0}}};
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         ndig_ff  <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         ndig_ff  <= ndig_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   `SDF_ASSERT(a_shift_ready, clock, reset, ctrl.shift |-> state_ff == ST_READY, "digit shift while converting")
   `SDF_ASSERT(a_norm_ndig, clock, reset, state_ff == ST_NORM |-> ndig_ff >= 4'd1 && ndig_ff <= 4'd10, "digit count out of range")
   `SDF_ASSERT(a_dabble_end, clock, reset, state_ff == ST_DABBLE && cnt_ff == CNT_LAST && !ctrl.start |=> state_ff == ST_NORM, "conversion did not finish after 32 bits")

endmodule

`default_nettype wire

FILE: rtl/signed_decimal_formatter.sv
// Signed decimal formatter: sign, zero padding and decimal digits of a
// printf style %d conversion, one ASCII character per output beat.
//
// Request channel (req_*): one beat carries a 32-bit signed value with the
// plus, space, zero and dot flags, a precision and a field width. req_stall
// is high while a value is being worked on; the next value is taken as soon
// as the last character sits in the output register, stalled or not.
//
// Response channel (rsp_*): one beat per character, sign first, then '0'
// padding, then digits MSB first. rsp_last marks the final character. A value
// that formats to nothing gives a single beat with rsp_empty_res set.
//
// Steps: serial shift-and-add-3 over all 32 bits of the magnitude, then
// stripping of leading zero digits down to the digit count of the magnitude
// (1..10), then a handoff that puts the first character in the output
// register. A value gives at most 64 characters; a new value is not taken
// until the last character of the previous one is loaded.
// Reset (synchronous, active high) drops rsp_valid and returns to idle.
// When the receiver stalls, the current character holds and the sequencer
// waits; nothing is dropped.
`default_nettype none
`include "assert_macros.svh"

module signed_decimal_formatter (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic signed [sdf_pkg::VALUE_W-1:0] req_value,
   input  wire logic                              req_plus_flag,
   input  wire logic                              req_space_flag,
   input  wire logic                              req_zero_flag,
   input  wire logic                              req_dot_flag,
   input  wire logic [sdf_pkg::PREC_W-1:0]        req_precision,
   input  wire logic [sdf_pkg::WIDTH_W-1:0]       req_field_width,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [sdf_pkg::CHAR_W-1:0]             rsp_char_code,
   output logic                                   rsp_last,
   output logic                                   rsp_empty_res,
   output logic                                   rsp_sign_used
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   localparam logic [sdf_pkg::WIDTH_W-1:0] WID_MAX =
      sdf_pkg::WIDTH_W'(sdf_pkg::MAX_OUT_CHARS);

   logic [1:0]                        state_ff, state_in;
   // per-value settings captured at accept
   logic [sdf_pkg::CHAR_W-1:0]        sign_char_ff, sign_char_in;
   logic                              sign_ff, sign_in;
   logic                              zero_flag_ff, zero_flag_in;
   logic                              dot_ff, dot_in;
   logic                              vzero_ff, vzero_in;
   logic [sdf_pkg::PREC_W-1:0]        prec_ff, prec_in;
   logic [sdf_pkg::WIDTH_W-1:0]       wid_ff, wid_in;
   // emission counters
   logic                              sign_pend_ff, sign_pend_in;
   logic                              empty_pend_ff, empty_pend_in;
   logic [sdf_pkg::WIDTH_W-1:0]       zeros_ff, zeros_in;
   logic [sdf_pkg::NDIG_W-1:0]        digits_ff, digits_in;
   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [sdf_pkg::CHAR_W-1:0]        char_ff, char_in;
   logic                              last_ff, last_in;
   logic                              empty_ff, empty_in;
   logic                              used_ff, used_in;

   sdf_pkg::conv_ctrl_type            conv_ctrl;
   sdf_pkg::conv_stat_type            conv_stat;
   logic [sdf_pkg::DIGIT_W-1:0]       top_digit;
   logic [sdf_pkg::VALUE_W-1:0]       req_mag;
   logic                              accept;
   logic                              load_ok;
   logic [sdf_pkg::WIDTH_W-1:0]       nd_w;
   logic [sdf_pkg::WIDTH_W-1:0]       nd_sign;
   logic [sdf_pkg::WIDTH_W-1:0]       zeros_calc;
   logic [sdf_pkg::NDIG_W-1:0]        digits_calc;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   // two's complement magnitude; the most negative value maps to 2^31
   assign req_mag   = req_value[sdf_pkg::VALUE_W-1] ? (~req_value + 1'b1) : req_value;
   assign load_ok   = !rsp_valid_ff || !rsp_stall;

   assign nd_w    = sdf_pkg::WIDTH_W'(conv_stat.ndig);
   assign nd_sign = nd_w + sdf_pkg::WIDTH_W'(sign_ff);

   always_comb begin
      zeros_calc = '0;
      if (dot_ff) begin
         if (sdf_pkg::WIDTH_W'(prec_ff) > nd_w) begin
            zeros_calc = sdf_pkg::WIDTH_W'(prec_ff) - nd_w;
         end
      end else if (zero_flag_ff && wid_ff > nd_sign) begin
         zeros_calc = wid_ff - nd_sign;
      end
      // "%.0d" of zero prints no digits
      digits_calc = (vzero_ff && dot_ff && prec_ff == '0) ? '0 : conv_stat.ndig;
   end

   sdf_bin2bcd u_bin2bcd (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (conv_ctrl),
      .mag       (req_mag),
      .stat      (conv_stat),
      .top_digit (top_digit)
   );

   always_comb begin
      state_in      = state_ff;
      sign_char_in  = sign_char_ff;
      sign_in       = sign_ff;
      zero_flag_in  = zero_flag_ff;
      dot_in        = dot_ff;
      vzero_in      = vzero_ff;
      prec_in       = prec_ff;
      wid_in        = wid_ff;
      sign_pend_in  = sign_pend_ff;
      empty_pend_in = empty_pend_ff;
      zeros_in      = zeros_ff;
      digits_in     = digits_ff;
      rsp_valid_in  = rsp_valid_ff;
      char_in       = char_ff;
      last_in       = last_ff;
      empty_in      = empty_ff;
      used_in       = used_ff;
      conv_ctrl.start = accept;
      conv_ctrl.shift = 1'b0;

      // output beat taken and nothing new loaded below
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in     = ST_CONV;
               sign_in      = req_plus_flag || req_space_flag ||
                              req_value[sdf_pkg::VALUE_W-1];
               sign_char_in = req_value[sdf_pkg::VALUE_W-1] ? sdf_pkg::CHAR_MINUS :
                              req_plus_flag                 ? sdf_pkg::CHAR_PLUS  :
                                                              sdf_pkg::CHAR_SPACE;
               zero_flag_in = req_zero_flag;
               dot_in       = req_dot_flag;
               vzero_in     = (req_value == '0);
               prec_in      = req_precision;
               wid_in       = (req_field_width > WID_MAX) ? WID_MAX : req_field_width;
            end
         end
         ST_CONV: begin
            if (conv_stat.done) begin
               state_in      = ST_EMIT;
               zeros_in      = zeros_calc;
               digits_in     = digits_calc;
               sign_pend_in  = sign_ff;
               empty_pend_in = !sign_ff && zeros_calc == '0 && digits_calc == '0;
            end
         end
         ST_EMIT: begin
            if (load_ok) begin
               rsp_valid_in = 1'b1;
               empty_in     = 1'b0;
               used_in      = sign_ff;
               if (empty_pend_ff) begin
                  char_in       = '0;
                  last_in       = 1'b1;
                  empty_in      = 1'b1;
                  empty_pend_in = 1'b0;
                  state_in      = ST_IDLE;
               end else if (sign_pend_ff) begin
                  char_in      = sign_char_ff;
                  last_in      = (zeros_ff == '0) && (digits_ff == '0);
                  sign_pend_in = 1'b0;
                  if (last_in) begin
                     state_in = ST_IDLE;
                  end
               end else if (zeros_ff != '0) begin
                  char_in  = sdf_pkg::CHAR_ZERO;
                  last_in  = (zeros_ff == 7'd1) && (digits_ff == '0);
                  zeros_in = zeros_ff - 1'b1;
                  if (last_in) begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  char_in         = sdf_pkg::CHAR_ZERO + sdf_pkg::CHAR_W'(top_digit);
                  last_in         = (digits_ff == 4'd1);
                  digits_in       = digits_ff - 1'b1;
                  conv_ctrl.shift = 1'b1;
                  if (last_in) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         sign_pend_ff  <= 1'b0;
         empty_pend_ff <= 1'b0;
         zeros_ff      <= '0;
         digits_ff     <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         sign_pend_ff  <= sign_pend_in;
         empty_pend_ff <= empty_pend_in;
         zeros_ff      <= zeros_in;
         digits_ff     <= digits_in;
      end
      sign_char_ff <= sign_char_in;
      sign_ff      <= sign_in;
      zero_flag_ff <= zero_flag_in;
      dot_ff       <= dot_in;
      vzero_ff     <= vzero_in;
      prec_ff      <= prec_in;
      wid_ff       <= wid_in;
      char_ff      <= char_in;
      last_ff      <= last_in;
      empty_ff     <= empty_in;
      used_ff      <= used_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;
   assign rsp_empty_res = empty_ff;
   assign rsp_sign_used = used_ff;

   `SDF_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid_ff && state_ff == ST_IDLE, "output not idle after reset")
   `SDF_ASSERT(a_empty_last, clock, reset, rsp_valid_ff && empty_ff |-> last_ff && !used_ff, "empty beat must be last with no sign")
   `SDF_ASSERT(a_shift_digits, clock, reset, conv_ctrl.shift |-> digits_ff != '0 && !sign_pend_ff && zeros_ff == '0, "digit emitted out of order")
   `SDF_ASSERT(a_emit_done, clock, reset, state_ff == ST_EMIT && !empty_pend_ff && !sign_pend_ff && zeros_ff == '0 && digits_ff == '0 |-> 1'b0, "emit phase with nothing left")

endmodule

`default_nettype wire
